FILE: src/itrd_pkg.sv
// Shared types, constants and the digit glyph function for the integer to
// radix digits unit. No dependencies.
package itrd_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned CharWidth     = 7;
  localparam int unsigned RadixWidth    = 8;
  localparam int unsigned DigitWidth    = 4;
  localparam int unsigned StackDepth    = 32;
  localparam int unsigned CntWidth      = $clog2(StackDepth + 1);
  localparam int unsigned IdxWidth      = $clog2(StackDepth);
  localparam int unsigned BitsPerStep   = 8;
  localparam int unsigned StepsPerDigit = ValueWidth / BitsPerStep;
  localparam int unsigned StepCntWidth  = $clog2(StepsPerDigit);

  localparam logic [RadixWidth-1:0] RadixReset = 8'd10;
  localparam logic [RadixWidth-1:0] RadixMin   = 8'd2;
  localparam logic [RadixWidth-1:0] RadixMax   = 8'd16;

  localparam logic [CharWidth-1:0] CharSpace   = 7'h20;
  localparam logic [CharWidth-1:0] CharMinus   = 7'h2D;
  localparam logic [CharWidth-1:0] CharZero    = 7'h30;
  localparam logic [CharWidth-1:0] CharLetterA = 7'h41;
  localparam logic [CharWidth-1:0] CharError   = 7'h00;

  typedef enum logic [2:0] {
    CH_SPACE,
    CH_MINUS,
    CH_DIGIT,
    CH_ZERO,
    CH_ERR
  } char_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      push;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_zero;
    logic radix_ok;
    logic negative;
    logic quot_zero;
    logic out_free;
    logic last_digit;
  } st_t;

  function automatic logic [CharWidth-1:0] digit_glyph(input logic [DigitWidth-1:0] d);
    if (d < DigitWidth'(10)) begin
      return CharZero + CharWidth'(d);
    end else begin
      return CharLetterA + CharWidth'(d) - CharWidth'(10);
    end
  endfunction

endpackage

FILE: src/itrd_dp.sv
// Datapath of the integer to radix digits unit: radix register, iterative
// divider, digit stack and output register. Depends on itrd_pkg.
module itrd_dp
  import itrd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RadixWidth-1:0] cfg_wdata_i,
  input  logic [ValueWidth-1:0] value_i,
  input  cmd_t                  cmd_i,
  output st_t                   st_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CharWidth-1:0]  char_code_o,
  output logic                  last_char_o,
  output logic                  bad_radix_o
);

  logic [RadixWidth-1:0] radix_q;
  logic                  neg_q;
  logic [ValueWidth-1:0] work_q;
  logic [DigitWidth-1:0] rem_q;
  logic [DigitWidth-1:0] stack_q [StackDepth];
  logic [CntWidth-1:0]   nd_q;
  logic                  out_valid_q;
  logic [CharWidth-1:0]  char_q;
  logic                  last_q;
  logic                  bad_q;

  logic [ValueWidth-1:0] mag;
  logic [ValueWidth-1:0] div_work;
  logic [DigitWidth-1:0] div_rem;
  logic [DigitWidth:0]   trial;
  logic [IdxWidth-1:0]   pop_idx;
  logic [DigitWidth-1:0] top_digit;
  logic [CharWidth-1:0]  char_sel;
  logic                  out_free;
  logic                  pop;

  assign mag = value_i[ValueWidth-1] ? (~value_i + ValueWidth'(1)) : value_i;

  // Restoring division: the dividend shifts out at the top while quotient
  // bits shift in at the bottom of the same register.
  always_comb begin
    div_work = work_q;
    div_rem  = rem_q;
    trial    = '0;
    for (int i = 0; i < BitsPerStep; i++) begin
      trial    = {div_rem, div_work[ValueWidth-1]};
      div_work = {div_work[ValueWidth-2:0], 1'b0};
      if (trial >= radix_q[DigitWidth:0]) begin
        div_rem     = DigitWidth'(trial - radix_q[DigitWidth:0]);
        div_work[0] = 1'b1;
      end else begin
        div_rem = trial[DigitWidth-1:0];
      end
    end
  end

  assign pop_idx   = IdxWidth'(nd_q - CntWidth'(1));
  assign top_digit = stack_q[pop_idx];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop       = cmd_i.emit && (cmd_i.sel == CH_DIGIT) && out_free;

  always_comb begin
    case (cmd_i.sel)
      CH_SPACE: char_sel = CharSpace;
      CH_MINUS: char_sel = CharMinus;
      CH_DIGIT: char_sel = digit_glyph(top_digit);
      CH_ZERO:  char_sel = CharZero;
      CH_ERR:   char_sel = CharError;
      default:  char_sel = CharError;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RadixReset;
      nd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        nd_q <= '0;
      end else if (cmd_i.push) begin
        nd_q <= nd_q + CntWidth'(1);
      end else if (pop) begin
        nd_q <= nd_q - CntWidth'(1);
      end
      if (cmd_i.emit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q  <= value_i[ValueWidth-1];
      work_q <= mag;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      work_q <= div_work;
      rem_q  <= cmd_i.push ? '0 : div_rem;
    end
    if (cmd_i.push) begin
      stack_q[nd_q[IdxWidth-1:0]] <= div_rem;
    end
    if (cmd_i.emit && out_free) begin
      char_q <= char_sel;
      last_q <= cmd_i.last;
      bad_q  <= (cmd_i.sel == CH_ERR);
    end
  end

  assign st_o.in_zero    = (value_i == '0);
  assign st_o.radix_ok   = (radix_q >= RadixMin) && (radix_q <= RadixMax);
  assign st_o.negative   = neg_q;
  assign st_o.quot_zero  = (div_work == '0);
  assign st_o.out_free   = out_free;
  assign st_o.last_digit = (nd_q == CntWidth'(1));

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;
  assign bad_radix_o = bad_q;

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (nd_q != CntWidth'(StackDepth)))
    else $error("digit stack overflow");

  a_pop_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.sel == CH_DIGIT) |-> (nd_q != '0))
    else $error("digit emitted from an empty stack");

endmodule

FILE: src/itrd_ctrl.sv
// Controller of the integer to radix digits unit: sequences acceptance,
// division steps and character emission. Depends on itrd_pkg.
module itrd_ctrl
  import itrd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  st_t  st_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SPACE,
    S_MINUS,
    S_DIGIT,
    S_ZSPACE,
    S_ZERO,
    S_ERR
  } state_e;

  state_e                  state_q;
  logic [StepCntWidth-1:0] cnt_q;
  logic                    accept;
  logic                    last_step;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign last_step  = (cnt_q == StepCntWidth'(StepsPerDigit - 1));

  always_comb begin
    cmd_o          = '0;
    cmd_o.sel      = CH_SPACE;
    cmd_o.load     = accept;
    case (state_q)
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.push     = last_step;
      end
      S_SPACE, S_ZSPACE: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = CH_SPACE;
      end
      S_MINUS: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = CH_MINUS;
      end
      S_DIGIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = CH_DIGIT;
        cmd_o.last = st_i.last_digit;
      end
      S_ZERO: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = CH_ZERO;
        cmd_o.last = 1'b1;
      end
      S_ERR: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = CH_ERR;
        cmd_o.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            if (st_i.in_zero) begin
              state_q <= S_ZSPACE;
            end else if (!st_i.radix_ok) begin
              state_q <= S_ERR;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + StepCntWidth'(1);
          if (last_step && st_i.quot_zero) begin
            state_q <= S_SPACE;
          end
        end
        S_SPACE: begin
          if (st_i.out_free) begin
            state_q <= st_i.negative ? S_MINUS : S_DIGIT;
          end
        end
        S_MINUS: begin
          if (st_i.out_free) begin
            state_q <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (st_i.out_free && st_i.last_digit) begin
            state_q <= S_IDLE;
          end
        end
        S_ZSPACE: begin
          if (st_i.out_free) begin
            state_q <= S_ZERO;
          end
        end
        S_ZERO, S_ERR: begin
          if (st_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_div_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !last_step) |=> (state_q == S_DIV))
    else $error("division left before all steps were done");

endmodule

FILE: src/integer_to_radix_digits_unit.sv
// Top level of the integer to radix digits unit: joins the controller and
// the datapath. Depends on itrd_pkg, itrd_ctrl and itrd_dp.
//
// Usage: each input transaction carries a signed 32-bit value. The unit
// answers with a string of ASCII characters in the radix held in the
// configuration register (reset value 10): a space, a '-' for negative
// values, then the digits most significant first, the final character
// flagged by last_char_o. Zero always yields a space then '0'. A nonzero
// value under a radix outside 2 to 16 yields one transaction with
// bad_radix_o and last_char_o set and a character code of zero.
// Both channels use valid and stall; a transaction completes when valid is
// high and stall is low. One value is worked on at a time: in_stall_o stays
// high from acceptance until the final character has been loaded into the
// output register, so the next value can be taken while that character still
// waits to be collected.
// Timing: the divider resolves 8 quotient bits per cycle, so each digit
// takes a full 32-bit division; the first character appears only once
// every digit has been stacked, and characters then leave one per cycle
// while the receiver does not stall. The longest work comes from the most
// negative value under radix 2. Stalling the output simply holds the
// current character and pauses the controller's character emission.
// Reset empties the output register and restores the radix to 10.
module integer_to_radix_digits_unit
  import itrd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RadixWidth-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ValueWidth-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CharWidth-1:0]  char_code_o,
  output logic                  last_char_o,
  output logic                  bad_radix_o
);

  cmd_t cmd;
  st_t  st;

  // The controller decides what happens each cycle; the datapath only acts
  // on its commands and reports status back.
  itrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  itrd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o),
    .bad_radix_o (bad_radix_o)
  );

  // An error transaction is always a lone, final, empty character.
  a_err_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_radix_o) |-> (last_char_o && char_code_o == CharError))
    else $error("malformed bad radix transaction");

endmodule
